### rtl/core/undirected_bit_adjacency_matrix_macros.svh
// Assertion helpers, sampled on clk and disabled while arst_n is low.
`ifndef UNDIRECTED_BIT_ADJACENCY_MATRIX_MACROS_SVH
`define UNDIRECTED_BIT_ADJACENCY_MATRIX_MACROS_SVH

// Same-cycle implication.
`define UBAM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define UBAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ubam_pkg.sv
package ubam_pkg;

	localparam int ROW_W = 64;
	localparam int CNT_W = 7;
	localparam int IDX_W = 6;
	localparam int CMD_W = 3;

	localparam int DEF_MAX_NODES = 64;
	localparam logic [CNT_W-1:0] ACTIVE_RST = 7'd64;

	localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REM_EDGE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REM_NODE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LIST     = 3'd4;

	// Bits below n set.
	function automatic logic [ROW_W-1:0] low_mask(input logic [CNT_W-1:0] n);
		logic [ROW_W-1:0] m;
		m = '0;
		for (int i = 0; i < ROW_W; i++) begin
			m[i] = (CNT_W'(i) < n);
		end
		return m;
	endfunction

endpackage

### rtl/core/ubam_ram.sv
module ubam_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/undirected_bit_adjacency_matrix.sv
// Undirected graph held as a bit matrix in one single-port-write, one-read RAM, one
// 64-bit row per node. After reset a clearing pass writes every row, one per cycle,
// with cmd_stall high; cfg writes are taken during it. Each command walks the RAM
// with one read and one write per cycle: an out-of-range index or unknown command
// answers at once, a query reads row a and answers, an edge add or remove reads row
// a, writes a while reading b, writes b and answers, and a self-loop add answers
// without touching the RAM. Remove node and a neighbour list step through the rows
// or bits one per cycle up to the active node count, the list holding while a find
// waits on a full response register. A new command is taken as soon as the previous
// answer sits in the response register; every command waits while rsp_stall holds it.
`include "undirected_bit_adjacency_matrix_macros.svh"

module undirected_bit_adjacency_matrix
	import ubam_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  logic [CMD_W-1:0] command,
	input  logic [IDX_W-1:0] node_a,
	input  logic [IDX_W-1:0] node_b,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic             status,
	output logic             connected,
	output logic [IDX_W-1:0] neighbour,
	output logic             neighbour_valid,
	output logic             last
);

	localparam int ROWS = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
	localparam int AW   = $clog2(ROWS);
	localparam logic [CNT_W-1:0] ROWS_N   = CNT_W'(ROWS);
	localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(ROWS - 1);

	localparam logic [3:0] ST_CLR      = 4'd0;
	localparam logic [3:0] ST_IDLE     = 4'd1;
	localparam logic [3:0] ST_RD_B     = 4'd2;
	localparam logic [3:0] ST_WR_B     = 4'd3;
	localparam logic [3:0] ST_QRY      = 4'd4;
	localparam logic [3:0] ST_LST_LOAD = 4'd5;
	localparam logic [3:0] ST_LST_SCAN = 4'd6;
	localparam logic [3:0] ST_RN_ROW   = 4'd7;
	localparam logic [3:0] ST_RN_COL   = 4'd8;
	localparam logic [3:0] ST_RESP     = 4'd9;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] active_q;
	logic [CNT_W-1:0] eff_n;
	logic [CMD_W-1:0] cmd_q, cmd_d;
	logic [IDX_W-1:0] a_q, a_d, b_q, b_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic             pend_v_q, pend_v_d;
	logic [IDX_W-1:0] pend_q, pend_d;
	logic             resp_status_q, resp_status_d;
	logic             resp_conn_q, resp_conn_d;
	logic             col_v_s1, col_v_d;
	logic [AW-1:0]    col_addr_s1, col_addr_d;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [ROW_W-1:0] ram_wdata, ram_rdata;
	logic [ROW_W-1:0] bit_a, bit_b;

	logic             out_valid_q, out_free, out_load;
	logic             out_status_d, out_conn_d, out_nbv_d, out_last_d;
	logic [IDX_W-1:0] out_nb_d;
	logic             status_q, connected_q, neighbour_valid_q, last_q;
	logic [IDX_W-1:0] neighbour_q;

	logic a_ok, b_ok;

	ubam_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROWS)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign eff_n    = (active_q > ROWS_N) ? ROWS_N : active_q;
	assign a_ok     = {1'b0, node_a} < eff_n;
	assign b_ok     = {1'b0, node_b} < eff_n;
	assign bit_a    = {{(ROW_W-1){1'b0}}, 1'b1} << a_q;
	assign bit_b    = {{(ROW_W-1){1'b0}}, 1'b1} << b_q;
	assign out_free = !out_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		cmd_d         = cmd_q;
		a_d           = a_q;
		b_d           = b_q;
		row_d         = row_q;
		pend_v_d      = pend_v_q;
		pend_d        = pend_q;
		resp_status_d = resp_status_q;
		resp_conn_d   = resp_conn_q;
		col_v_d       = col_v_s1;
		col_addr_d    = col_addr_s1;
		ram_we        = 1'b0;
		ram_waddr     = a_q[AW-1:0];
		ram_wdata     = '0;
		ram_raddr     = a_q[AW-1:0];
		out_load      = 1'b0;
		out_status_d  = 1'b0;
		out_conn_d    = 1'b0;
		out_nb_d      = '0;
		out_nbv_d     = 1'b0;
		out_last_d    = 1'b1;
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				if (idx_q == LAST_ROW) begin
					idx_d   = '0;
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_d         = command;
					a_d           = node_a;
					b_d           = node_b;
					ram_raddr     = node_a[AW-1:0];
					resp_status_d = 1'b0;
					resp_conn_d   = 1'b0;
					state_d       = ST_RESP;
					case (command)
						CMD_ADD_EDGE: begin
							if (!a_ok || !b_ok) begin
								resp_status_d = 1'b1;
							end else if (node_a != node_b) begin
								state_d = ST_RD_B;
							end
						end
						CMD_REM_EDGE: begin
							if (!a_ok || !b_ok) resp_status_d = 1'b1;
							else state_d = ST_RD_B;
						end
						CMD_REM_NODE: begin
							if (!a_ok) resp_status_d = 1'b1;
							else state_d = ST_RN_ROW;
						end
						CMD_QUERY: begin
							if (!a_ok || !b_ok) resp_status_d = 1'b1;
							else state_d = ST_QRY;
						end
						CMD_LIST: begin
							if (!a_ok) resp_status_d = 1'b1;
							else state_d = ST_LST_LOAD;
						end
						default: begin
							resp_status_d = 1'b1;
						end
					endcase
				end
			end
			ST_RD_B: begin
				ram_we    = 1'b1;
				ram_waddr = a_q[AW-1:0];
				ram_wdata = (cmd_q == CMD_ADD_EDGE) ? (ram_rdata | bit_b)
					: (ram_rdata & ~bit_b);
				ram_raddr = b_q[AW-1:0];
				state_d   = ST_WR_B;
			end
			ST_WR_B: begin
				ram_we    = 1'b1;
				ram_waddr = b_q[AW-1:0];
				ram_wdata = (cmd_q == CMD_ADD_EDGE) ? (ram_rdata | bit_a)
					: (ram_rdata & ~bit_a);
				state_d   = ST_RESP;
			end
			ST_QRY: begin
				resp_conn_d = ram_rdata[b_q];
				state_d     = ST_RESP;
			end
			ST_LST_LOAD: begin
				row_d    = ram_rdata & low_mask(eff_n);
				idx_d    = '0;
				pend_v_d = 1'b0;
				state_d  = ST_LST_SCAN;
			end
			ST_LST_SCAN: begin
				if (idx_q == eff_n) begin
					if (out_free) begin
						out_load  = 1'b1;
						out_nb_d  = pend_v_q ? pend_q : '0;
						out_nbv_d = pend_v_q;
						idx_d     = '0;
						state_d   = ST_IDLE;
					end
				end else if (row_q[0]) begin
					if (!pend_v_q || out_free) begin
						// found one; the previous find goes out as not last
						out_load   = pend_v_q;
						out_nb_d   = pend_q;
						out_nbv_d  = 1'b1;
						out_last_d = 1'b0;
						pend_v_d   = 1'b1;
						pend_d     = idx_q[IDX_W-1:0];
						row_d      = row_q >> 1;
						idx_d      = idx_q + CNT_W'(1);
					end
				end else begin
					row_d = row_q >> 1;
					idx_d = idx_q + CNT_W'(1);
				end
			end
			ST_RN_ROW: begin
				ram_we    = 1'b1;
				ram_waddr = a_q[AW-1:0];
				ram_wdata = ram_rdata & ~low_mask(eff_n);
				idx_d     = '0;
				col_v_d   = 1'b0;
				state_d   = ST_RN_COL;
			end
			ST_RN_COL: begin
				if (col_v_s1) begin
					ram_we    = 1'b1;
					ram_waddr = col_addr_s1;
					ram_wdata = ram_rdata & ~bit_a;
				end
				if (idx_q != eff_n) begin
					// row a's active bits were already cleared, skip it
					ram_raddr  = idx_q[AW-1:0];
					col_v_d    = (idx_q[IDX_W-1:0] != a_q);
					col_addr_d = idx_q[AW-1:0];
					idx_d      = idx_q + CNT_W'(1);
				end else begin
					col_v_d = 1'b0;
					if (!col_v_s1) begin
						idx_d   = '0;
						state_d = ST_RESP;
					end
				end
			end
			ST_RESP: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_status_d = resp_status_q;
					out_conn_d   = resp_conn_q;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			idx_q       <= '0;
			pend_v_q    <= 1'b0;
			col_v_s1    <= 1'b0;
			active_q    <= ACTIVE_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			pend_v_q <= pend_v_d;
			col_v_s1 <= col_v_d;
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q         <= cmd_d;
		a_q           <= a_d;
		b_q           <= b_d;
		row_q         <= row_d;
		pend_q        <= pend_d;
		resp_status_q <= resp_status_d;
		resp_conn_q   <= resp_conn_d;
		col_addr_s1   <= col_addr_d;
		if (out_load) begin
			status_q          <= out_status_d;
			connected_q       <= out_conn_d;
			neighbour_q       <= out_nb_d;
			neighbour_valid_q <= out_nbv_d;
			last_q            <= out_last_d;
		end
	end

	assign rsp_valid       = out_valid_q;
	assign status          = status_q;
	assign connected       = connected_q;
	assign neighbour       = neighbour_q;
	assign neighbour_valid = neighbour_valid_q;
	assign last            = last_q;

	`UBAM_ASSERT_IMPL(a_clr_quiet, state_q == ST_CLR, !out_valid_q, "response during clear pass")
	`UBAM_ASSERT_IMPL(a_no_overwrite, out_load, out_free, "response register overwritten")
	`UBAM_ASSERT_IMPL(a_scan_bound, state_q == ST_LST_SCAN, idx_q <= eff_n, "scan past node count")
	`UBAM_ASSERT_IMPL(a_col_skip_a, (state_q == ST_RN_COL) && ram_we,
		ram_waddr != a_q[AW-1:0], "column pass rewrote removed row")
	`UBAM_ASSERT_NEXT(a_col_done, (state_q == ST_RN_COL) && (idx_q == eff_n) && !col_v_s1,
		state_q == ST_RESP, "node removal did not finish")

endmodule
